/* rtl/core/ble_adx_pkg.sv */
`timescale 1ns / 1ps

package ble_adx_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPANIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICES  = 1'd1;

    localparam logic [BYTE_W-1:0] AD_MFR_DATA    = 8'hFF;
    localparam logic [BYTE_W-1:0] AD_SVC16_PART  = 8'h02;
    localparam logic [BYTE_W-1:0] AD_SVC16_FULL  = 8'h03;
    localparam logic [BYTE_W-1:0] AD_SVC32_PART  = 8'h04;
    localparam logic [BYTE_W-1:0] AD_SVC32_FULL  = 8'h05;
    localparam logic [BYTE_W-1:0] AD_SVC128_PART = 8'h06;
    localparam logic [BYTE_W-1:0] AD_SVC128_FULL = 8'h07;

    localparam logic [KIND_W-1:0] ID_COMPANY = 2'd0;
    localparam logic [KIND_W-1:0] ID_SVC16   = 2'd1;
    localparam logic [KIND_W-1:0] ID_SVC32   = 2'd2;
    localparam logic [KIND_W-1:0] ID_SVC128  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] payload_len;
        logic              first_byte;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]  id_kind;
        logic [VALUE_W-1:0] value_low;
        logic [VALUE_W-1:0] value_high;
    } t_result;

    typedef struct packed {
        logic collect_companies;
        logic collect_services;
    } t_cfg;

endpackage

/* rtl/core/ble_adx_in_if.sv */
`timescale 1ns / 1ps

interface ble_adx_in_if;
    logic                             valid;
    logic                             ready;
    logic [ble_adx_pkg::BYTE_W-1:0]   data_byte;
    logic [ble_adx_pkg::BYTE_W-1:0]   payload_len;
    logic                             first_byte;

    modport source (output valid, output data_byte, output payload_len, output first_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input payload_len, input first_byte,
                    output ready);
endinterface

/* rtl/core/ble_adx_out_if.sv */
`timescale 1ns / 1ps

interface ble_adx_out_if;
    logic                              valid;
    logic                              ready;
    logic [ble_adx_pkg::KIND_W-1:0]    id_kind;
    logic [ble_adx_pkg::VALUE_W-1:0]   value_low;
    logic [ble_adx_pkg::VALUE_W-1:0]   value_high;

    modport source (output valid, output id_kind, output value_low, output value_high,
                    input ready);
    modport sink   (input valid, input id_kind, input value_low, input value_high,
                    output ready);
endinterface

/* rtl/core/ble_ad_record_uuid_extractor.sv */
`timescale 1ns / 1ps

// channel   dir  payload                                handshake
// i_item    in   data_byte[8] payload_len[8] first_byte valid/ready
// o_result  out  id_kind[2] value_low[64] value_high[64] valid/ready
// i_cfg_*   in   idx 0 collect_companies, 1 collect_services  i_cfg_we
//
// One item per cycle sustained while the result is not stalled; an item
// passes the input register and the walk update into the result register.
// Synchronous active-low reset clears the walk and sets both collect flags.
// A stalled result holds the result register; items flow while it is free
// or being drained, else ready drops once the input register is full.

module ble_ad_record_uuid_extractor (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    ble_adx_in_if.sink                             i_item,
    ble_adx_out_if.source                          o_result,
    input  logic                                   i_cfg_we,
    input  logic [ble_adx_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ble_adx_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    logic                  r_in_valid;
    ble_adx_pkg::t_item    r_in_item;
    ble_adx_pkg::t_cfg     r_cfg;
    logic                  walk_ready;
    logic                  res_valid;
    ble_adx_pkg::t_result  res;

    assign i_item.ready = !r_in_valid || walk_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_item.data_byte   <= i_item.data_byte;
            r_in_item.payload_len <= i_item.payload_len;
            r_in_item.first_byte  <= i_item.first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.collect_companies <= 1'b1;
            r_cfg.collect_services  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ble_adx_pkg::CFG_COMPANIES: r_cfg.collect_companies <= i_cfg_data[0];
                ble_adx_pkg::CFG_SERVICES:  r_cfg.collect_services  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ble_adx_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .o_ready     (walk_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (o_result.ready)
    );

    assign o_result.valid      = res_valid;
    assign o_result.id_kind    = res.id_kind;
    assign o_result.value_low  = res.value_low;
    assign o_result.value_high = res.value_high;

endmodule

/* rtl/core/ble_adx_walk.sv */
`timescale 1ns / 1ps

module ble_adx_walk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ble_adx_pkg::t_item    i_item,
    input  ble_adx_pkg::t_cfg     i_cfg,
    output logic                  o_ready,
    output logic                  o_res_valid,
    output ble_adx_pkg::t_result  o_res,
    input  logic                  i_res_ready
);

    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_TYPE   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    localparam int unsigned ASM_W   = 2 * ble_adx_pkg::VALUE_W;
    localparam int unsigned NBYTES  = ASM_W / ble_adx_pkg::BYTE_W;

    logic [7:0]       r_pos,   n_pos;
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_left,  n_left;
    logic [7:0]       r_kind,  n_kind;
    logic [4:0]       r_gcnt,  n_gcnt;
    logic [ASM_W-1:0] r_asm,   n_asm;
    logic             r_stop,  n_stop;
    logic             r_ctake, n_ctake;

    logic                  r_res_valid;
    ble_adx_pkg::t_result  r_res, n_res;

    logic             accept;
    logic             emit;
    logic [7:0]       e_pos;
    logic [1:0]       e_phase;
    logic [7:0]       e_left;
    logic [4:0]       e_gcnt;
    logic             e_stop;
    logic             e_ctake;
    logic [4:0]       gsize;
    logic [1:0]       okind;
    logic             is_company;
    logic [3:0]       k;
    logic [4:0]       k_next;
    logic [ASM_W-1:0] asm_ins;
    logic [8:0]       pos_next;
    logic [8:0]       rec_end;
    logic             on;

    assign o_ready = !r_res_valid || i_res_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        unique case (r_kind)
            ble_adx_pkg::AD_MFR_DATA: begin
                gsize = 5'd2;
                okind = ble_adx_pkg::ID_COMPANY;
            end
            ble_adx_pkg::AD_SVC16_PART, ble_adx_pkg::AD_SVC16_FULL: begin
                gsize = 5'd2;
                okind = ble_adx_pkg::ID_SVC16;
            end
            ble_adx_pkg::AD_SVC32_PART, ble_adx_pkg::AD_SVC32_FULL: begin
                gsize = 5'd4;
                okind = ble_adx_pkg::ID_SVC32;
            end
            ble_adx_pkg::AD_SVC128_PART, ble_adx_pkg::AD_SVC128_FULL: begin
                gsize = 5'd16;
                okind = ble_adx_pkg::ID_SVC128;
            end
            default: begin
                gsize = 5'd0;
                okind = ble_adx_pkg::ID_COMPANY;
            end
        endcase
    end

    assign is_company = (r_kind == ble_adx_pkg::AD_MFR_DATA);
    assign on = is_company ? i_cfg.collect_companies : i_cfg.collect_services;

    always_comb begin
        e_pos   = i_item.first_byte ? 8'd0 : r_pos;
        e_phase = i_item.first_byte ? PH_LENGTH : r_phase;
        e_left  = i_item.first_byte ? 8'd0 : r_left;
        e_gcnt  = i_item.first_byte ? 5'd0 : r_gcnt;
        e_stop  = i_item.first_byte ? 1'b0 : r_stop;
        e_ctake = i_item.first_byte ? 1'b0 : r_ctake;

        k        = e_gcnt[3:0];
        k_next   = {1'b0, k} + 5'd1;
        asm_ins  = r_asm;
        for (int i = 0; i < NBYTES; i++) begin
            if (k == i[3:0]) begin
                asm_ins[i*ble_adx_pkg::BYTE_W +: ble_adx_pkg::BYTE_W] =
                    r_asm[i*ble_adx_pkg::BYTE_W +: ble_adx_pkg::BYTE_W] | i_item.data_byte;
            end
        end
        pos_next = {1'b0, e_pos} + 9'd1;
        rec_end  = pos_next + {1'b0, i_item.data_byte};

        n_pos   = e_pos;
        n_phase = e_phase;
        n_left  = e_left;
        n_kind  = r_kind;
        n_gcnt  = e_gcnt;
        n_asm   = r_asm;
        n_stop  = e_stop;
        n_ctake = e_ctake;
        emit    = 1'b0;

        n_res.id_kind    = okind;
        n_res.value_low  = asm_ins[ble_adx_pkg::VALUE_W-1:0];
        n_res.value_high = asm_ins[ASM_W-1:ble_adx_pkg::VALUE_W];

        if (!e_stop) begin
            n_pos = (e_pos == 8'hFF) ? e_pos : pos_next[7:0];
            unique case (e_phase)
                PH_TYPE: begin
                    n_kind  = i_item.data_byte;
                    n_left  = e_left - 8'd1;
                    n_gcnt  = 5'd0;
                    n_asm   = '0;
                    n_ctake = 1'b0;
                    n_phase = (n_left == 8'd0) ? PH_LENGTH : PH_DATA;
                end
                PH_DATA: begin
                    if (gsize != 5'd0 && !(is_company && e_ctake)) begin
                        n_asm  = asm_ins;
                        n_gcnt = k_next;
                        if (k_next >= gsize) begin
                            emit   = on;
                            n_ctake = e_ctake || is_company;
                            n_gcnt = 5'd0;
                            n_asm  = '0;
                        end
                    end
                    n_left = e_left - 8'd1;
                    if (n_left == 8'd0) begin
                        n_phase = PH_LENGTH;
                    end
                end
                default: begin
                    if (pos_next >= {1'b0, i_item.payload_len} || i_item.data_byte == 8'd0
                        || rec_end > {1'b0, i_item.payload_len}) begin
                        n_stop  = 1'b1;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_left  = i_item.data_byte;
                        n_phase = PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= PH_LENGTH;
            r_left      <= '0;
            r_kind      <= '0;
            r_gcnt      <= '0;
            r_asm       <= '0;
            r_stop      <= 1'b0;
            r_ctake     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_left  <= n_left;
                r_kind  <= n_kind;
                r_gcnt  <= n_gcnt;
                r_asm   <= n_asm;
                r_stop  <= n_stop;
                r_ctake <= n_ctake;
            end
            if (accept && emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* tb/ble_ad_record_uuid_extractor_checker.sv */
`timescale 1ns / 1ps

module ble_ad_record_uuid_extractor_checker
    import ble_adx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ble_adx_in_if                i_item,
    ble_adx_out_if               i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_ids_checked
);

    typedef enum logic [1:0] {WALK_LENGTH, WALK_TYPE, WALK_DATA} t_walk_phase;

    logic                collect_co;
    logic                collect_svc;
    logic [BYTE_W-1:0]   walk_pos;
    t_walk_phase         walk_ph;
    logic [BYTE_W-1:0]   record_left;
    logic [BYTE_W-1:0]   rec_type;
    logic [4:0]          bytes_in_id;
    logic [VALUE_W-1:0]  acc_lo;
    logic [VALUE_W-1:0]  acc_hi;
    logic                walk_halted;
    logic                company_done;

    t_result             pending_ids[$];
    int                  mismatches;
    int                  checked;

    task automatic report(input string why, input t_result want, input t_result got);
        if (mismatches < 10) begin
            $display("tb: %s: expected kind %0d low %h high %h, got kind %0d low %h high %h",
                     why, want.id_kind, want.value_low, want.value_high,
                     got.id_kind, got.value_low, got.value_high);
        end
        mismatches++;
    endtask

    task automatic walk_byte(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] plen,
                             input logic first);
        int                at;
        int                need;
        int                slot;
        logic [KIND_W-1:0] kind_out;
        logic              emit;
        t_result           found;
        if (first) begin
            walk_pos     = '0;
            walk_ph      = WALK_LENGTH;
            walk_halted  = 1'b0;
            record_left  = '0;
            bytes_in_id  = '0;
            company_done = 1'b0;
        end
        if (walk_halted) return;
        at = int'(walk_pos);
        if (walk_pos != 8'hFF) walk_pos = walk_pos + 8'd1;
        case (walk_ph)
            WALK_TYPE: begin
                rec_type     = b;
                record_left  = record_left - 8'd1;
                bytes_in_id  = '0;
                acc_lo       = '0;
                acc_hi       = '0;
                company_done = 1'b0;
                walk_ph      = (record_left == 0) ? WALK_LENGTH : WALK_DATA;
            end
            WALK_DATA: begin
                case (rec_type)
                    AD_MFR_DATA: begin
                        need = 2;
                        kind_out = ID_COMPANY;
                    end
                    AD_SVC16_PART, AD_SVC16_FULL: begin
                        need = 2;
                        kind_out = ID_SVC16;
                    end
                    AD_SVC32_PART, AD_SVC32_FULL: begin
                        need = 4;
                        kind_out = ID_SVC32;
                    end
                    AD_SVC128_PART, AD_SVC128_FULL: begin
                        need = 16;
                        kind_out = ID_SVC128;
                    end
                    default: begin
                        need = 0;
                        kind_out = ID_COMPANY;
                    end
                endcase
                if (need != 0 && !(rec_type == AD_MFR_DATA && company_done)) begin
                    slot = int'(bytes_in_id[3:0]);
                    if (slot < 8) acc_lo[8*slot +: 8] = b;
                    else acc_hi[8*(slot-8) +: 8] = b;
                    bytes_in_id = 5'(slot + 1);
                    if (int'(bytes_in_id) >= need) begin
                        emit = (rec_type == AD_MFR_DATA) ? collect_co : collect_svc;
                        if (emit) begin
                            found.id_kind    = kind_out;
                            found.value_low  = acc_lo;
                            found.value_high = acc_hi;
                            pending_ids = {pending_ids, found};
                        end
                        if (rec_type == AD_MFR_DATA) company_done = 1'b1;
                        bytes_in_id = '0;
                        acc_lo      = '0;
                        acc_hi      = '0;
                    end
                end
                record_left = record_left - 8'd1;
                if (record_left == 0) walk_ph = WALK_LENGTH;
            end
            default: begin
                if (at + 1 >= int'(plen) || b == 0 || at + 1 + int'(b) > int'(plen)) begin
                    walk_halted = 1'b1;
                    walk_ph     = WALK_LENGTH;
                end else begin
                    record_left = b;
                    walk_ph     = WALK_TYPE;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            collect_co   = 1'b1;
            collect_svc  = 1'b1;
            walk_pos     = '0;
            walk_ph      = WALK_LENGTH;
            record_left  = '0;
            rec_type     = '0;
            bytes_in_id  = '0;
            acc_lo       = '0;
            acc_hi       = '0;
            walk_halted  = 1'b0;
            company_done = 1'b0;
            pending_ids.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.id_kind    = i_result.id_kind;
                got.value_low  = i_result.value_low;
                got.value_high = i_result.value_high;
                if (pending_ids.size() == 0) begin
                    report("identifier with none pending", '0, got);
                end else begin
                    want = pending_ids.pop_front();
                    checked++;
                    if (got.id_kind !== want.id_kind || got.value_low !== want.value_low ||
                        got.value_high !== want.value_high) begin
                        report("identifier mismatch", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COMPANIES) collect_co = i_cfg_data[0];
                else if (i_cfg_idx == CFG_SERVICES) collect_svc = i_cfg_data[0];
            end
            if (i_item.valid && i_item.ready) begin
                walk_byte(i_item.data_byte, i_item.payload_len, i_item.first_byte);
            end
        end
        o_pending     <= pending_ids.size();
        o_fail_count  <= mismatches;
        o_ids_checked <= checked;
    end

endmodule

/* tb/ble_ad_record_uuid_extractor_test.sv */
`timescale 1ns / 1ps

module ble_ad_record_uuid_extractor_test;
    import ble_adx_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 64;
    localparam int SETTLE_CYCLES = 6;

    localparam logic [BYTE_W-1:0] AD_LOCAL_NAME = 8'h09;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;

    ble_adx_in_if  item_ch();
    ble_adx_out_if result_ch();

    int fail_count;
    int pending;
    int ids_checked;
    int items_sent;
    int cycle_count;

    logic idle_on;
    logic pressure_armed;

    logic [BYTE_W-1:0] ad_bytes[$];

    ble_ad_record_uuid_extractor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ble_ad_record_uuid_extractor_checker id_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_ids_checked (ids_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : result_sink
        int hold_left;
        int stall_left;
        bit pressure_done;
        hold_left = 0;
        stall_left = 0;
        pressure_done = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_ch.ready <= 1'b0;
            end else if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] plen,
                             input logic first);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.data_byte   <= b;
        item_ch.payload_len <= plen;
        item_ch.first_byte  <= first;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic send_bytes(input int n_send, input logic [BYTE_W-1:0] plen,
                              input logic start, input bit vary_len, input bit stray);
        for (int i = 0; i < n_send; i++) begin
            send_byte(ad_bytes[i], vary_len ? BYTE_W'($urandom()) : plen,
                      (i == 0) ? start : (stray && $urandom_range(0, 99) == 0));
        end
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b);
        ad_bytes = {ad_bytes, b};
    endtask

    // fill ad_bytes with length/type/data records up to a random budget
    task automatic build_records();
        int budget;
        int n_data;
        logic [BYTE_W-1:0] rtype;
        ad_bytes.delete();
        budget = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 250) : $urandom_range(3, 31);
        while (ad_bytes.size() + 2 <= budget) begin
            case ($urandom_range(0, 8))
                0, 1: begin
                    rtype = AD_MFR_DATA;
                    n_data = $urandom_range(1, 6);
                end
                2: begin
                    rtype = $urandom_range(0, 1) ? AD_SVC16_FULL : AD_SVC16_PART;
                    n_data = 2 * $urandom_range(1, 4);
                end
                3: begin
                    rtype = $urandom_range(0, 1) ? AD_SVC32_FULL : AD_SVC32_PART;
                    n_data = 4 * $urandom_range(1, 3);
                end
                4, 5: begin
                    rtype = $urandom_range(0, 1) ? AD_SVC128_FULL : AD_SVC128_PART;
                    n_data = 16 * $urandom_range(1, 2);
                end
                6: begin
                    rtype = BYTE_W'($urandom());
                    if (rtype == AD_MFR_DATA ||
                        (rtype >= AD_SVC16_PART && rtype <= AD_SVC128_FULL)) begin
                        rtype = AD_LOCAL_NAME;
                    end
                    n_data = $urandom_range(0, 5);
                end
                default: begin
                    rtype = AD_SVC16_PART + BYTE_W'($urandom_range(0, 5));
                    n_data = $urandom_range(0, 20);
                end
            endcase
            if ($urandom_range(0, 4) == 0) n_data += $urandom_range(1, 3);
            if (ad_bytes.size() + 2 + n_data > budget) n_data = budget - ad_bytes.size() - 2;
            add_byte(BYTE_W'(n_data + 1));
            add_byte(rtype);
            repeat (n_data) add_byte(BYTE_W'($urandom()));
        end
    endtask

    task automatic random_payload();
        int n_send;
        logic [BYTE_W-1:0] plen;
        logic start;
        bit vary_len;
        build_records();
        plen = BYTE_W'(ad_bytes.size());
        n_send = ad_bytes.size();
        start = 1'b1;
        vary_len = 1'b0;
        case ($urandom_range(0, 19))
            0, 1: begin
                // a record runs past the payload end
                if (plen > 2) plen = BYTE_W'($urandom_range(2, int'(plen) - 1));
            end
            2: begin
                add_byte(BYTE_W'($urandom()));
                n_send = ad_bytes.size();
                plen = BYTE_W'(n_send);
            end
            3: begin
                add_byte(8'h00);
                repeat ($urandom_range(0, 3)) add_byte(BYTE_W'($urandom()));
                n_send = ad_bytes.size();
                plen = BYTE_W'(n_send);
            end
            4, 5: begin
                // cut short by the next payload start
                n_send = $urandom_range(1, n_send);
                plen = BYTE_W'($urandom_range(int'(plen), 255));
            end
            6: start = 1'b0;
            7: vary_len = 1'b1;
            8: begin
                ad_bytes.delete();
                repeat ($urandom_range(1, 12)) add_byte(BYTE_W'($urandom()));
                n_send = ad_bytes.size();
                plen = BYTE_W'($urandom_range(0, 255));
                start = 1'($urandom());
                vary_len = 1'($urandom());
            end
            default: ;
        endcase
        send_bytes(n_send, plen, start, vary_len, 1'b1);
    endtask

    task automatic run_phase(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) random_payload();
    endtask

    // drop valid, then wait for the last identifier and the pipeline to empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flags(input logic companies, input logic services);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_COMPANIES;
        cfg_data <= companies;
        @(posedge i_clk);
        cfg_idx  <= CFG_SERVICES;
        cfg_data <= services;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = CFG_COMPANIES;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.data_byte   = '0;
        item_ch.payload_len = '0;
        item_ch.first_byte  = 1'b0;
        idle_on             = 1'b0;
        pressure_armed      = 1'b0;
        items_sent          = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;

        // zero payload length halts at once
        ad_bytes = '{8'h03};
        send_bytes(1, 8'd0, 1'b1, 1'b0, 1'b0);
        // extreme company id with spare bytes, partial service16 group,
        // then a length byte in the final slot
        ad_bytes = '{8'h04, AD_MFR_DATA, 8'hFF, 8'hFF, 8'hAB,
                     8'h04, AD_SVC16_FULL, 8'h00, 8'h00, 8'hFF, 8'h01};
        send_bytes(11, 8'd11, 1'b1, 1'b0, 1'b0);
        // service32 then a truncated record
        ad_bytes = '{8'h05, AD_SVC32_PART, 8'h78, 8'h56, 8'h34, 8'h12, 8'h05};
        send_bytes(7, 8'd9, 1'b1, 1'b0, 1'b0);
        // skipped record type, then a zero length
        ad_bytes = '{8'h02, AD_LOCAL_NAME, 8'h41, 8'h00};
        send_bytes(4, 8'd255, 1'b1, 1'b0, 1'b0);
        settle();

        pressure_armed <= 1'b1;
        run_phase(110);
        settle();
        write_flags(1'b0, 1'b1);
        run_phase(80);
        settle();
        write_flags(1'b1, 1'b0);
        run_phase(80);
        settle();
        write_flags(1'b0, 1'b0);
        run_phase(50);
        settle();
        write_flags(1'b1, 1'b1);
        run_phase(90);
        idle_on <= 1'b0;
        run_phase(90);
        settle();

        $display("tb: %0d payload bytes walked, %0d identifiers compared", items_sent, ids_checked);
        $display("tb: collect flags stepped through all four settings, with a long output stall");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ble_adx_pkg.sv
rtl/core/ble_adx_in_if.sv
rtl/core/ble_adx_out_if.sv
rtl/core/ble_adx_walk.sv
rtl/core/ble_ad_record_uuid_extractor.sv
tb/ble_ad_record_uuid_extractor_checker.sv
tb/ble_ad_record_uuid_extractor_test.sv
